// File: src/tbf_pkg.sv
// Package with the shared types, widths and constants of the burst-fire modulator.
`timescale 1ns / 1ps

package tbf_pkg;

    // Field widths.
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned DEMAND_W = 11;
    localparam int unsigned RES_W    = 10;
    localparam int unsigned DELAY_W  = 8;
    localparam int unsigned DEBT_W   = 16;
    localparam int unsigned TICK_W   = 8;
    localparam int unsigned ENERGY_W = 32;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = RES_W;

    // Register reset values.
    localparam logic [RES_W-1:0]   RESOLUTION_RST  = RES_W'(100);
    localparam logic [DELAY_W-1:0] PHASE_DELAY_RST = '0;

    // Zero-cross qualification and tick counter limits.
    localparam logic [TICK_W-1:0] MIN_CROSS_TICKS = TICK_W'(2);
    localparam logic [TICK_W-1:0] TICK_MAX        = TICK_W'(255);

    // Event codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_ZERO_CROSS   = 2'd0,
        KIND_PHASE_TICK   = 2'd1,
        KIND_RT_TICK      = 2'd2,
        KIND_CLEAR_ENERGY = 2'd3
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESOLUTION  = 1'd0,
        CFG_PHASE_DELAY = 1'd1
    } cfg_idx_t;

endpackage

// File: src/tbf_evt_if.sv
// Interface for the event channel: valid, ready and the event payload.
`timescale 1ns / 1ps

interface tbf_evt_if
    import tbf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [DEMAND_W-1:0] power_demand;

    modport source (output valid, output kind, output power_demand, input ready);
    modport sink   (input valid, input kind, input power_demand, output ready);
endinterface

// File: src/tbf_res_if.sv
// Interface for the result channel: valid, ready and the result payload.
`timescale 1ns / 1ps

interface tbf_res_if
    import tbf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                heater_on;
    logic                decided;
    logic [ENERGY_W-1:0] energy_count;

    modport source (output valid, output heater_on, output decided, output energy_count,
                    input ready);
    modport sink   (input valid, input heater_on, input decided, input energy_count,
                    output ready);
endinterface

// File: src/triac_burst_fire_modulator_core.sv
// Top level of the zero-cross burst-fire triac modulator.
//
//   Channel   Dir  Payload                                  Handshake
//   evt_ch    in   kind[1:0], power_demand[10:0] signed     valid/ready
//   res_ch    out  heater_on, decided, energy_count[31:0]   valid/ready
//   cfg       in   cfg_index[0], cfg_data[9:0]              cfg_we, no wait
//
// An accepted event is held in the input register, then updates the state
// and loads the result register.
// One event is accepted per cycle while the result side keeps taking results.
// A stalled result holds the result register; the input register still takes
// one more event, after which evt_ch.ready drops.
// Reset clears all state, loads the register defaults and empties both stages.
`timescale 1ns / 1ps

module triac_burst_fire_modulator_core
    import tbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tbf_evt_if.sink               evt_ch,
    tbf_res_if.source             res_ch
);

    // Configuration registers.
    logic [RES_W-1:0]   resolution_reg;
    logic [DELAY_W-1:0] phase_delay_reg;

    // Input stage.
    logic                       s1_valid_reg;
    kind_t                      s1_kind_reg;
    logic signed [DEMAND_W-1:0] s1_demand_reg;

    // Modulator state.
    logic [DEBT_W-1:0]   debt_reg,      debt_next;
    logic [TICK_W-1:0]   ticks_reg,     ticks_next;
    logic [DELAY_W-1:0]  phase_cnt_reg, phase_cnt_next;
    logic                armed_reg,     armed_next;
    logic                heater_reg,    heater_next;
    logic [ENERGY_W-1:0] energy_reg,    energy_next;
    logic                decided_next;

    // Result register.
    logic                out_valid_reg;
    logic                out_heater_reg;
    logic                out_decided_reg;
    logic [ENERGY_W-1:0] out_energy_reg;

    logic s1_adv;
    logic s1_fire;
    logic evt_fire;

    // Decision datapath.
    logic signed [DEMAND_W-1:0] res_signed;
    logic signed [DEMAND_W-1:0] demand_clamped;
    logic [DEBT_W:0]            debt_sum;
    logic [DEBT_W:0]            debt_less;

    // Pipeline flow control.
    assign s1_adv   = !out_valid_reg || res_ch.ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign evt_fire = evt_ch.valid && evt_ch.ready;
    assign evt_ch.ready = !s1_valid_reg || s1_adv;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg  <= RESOLUTION_RST;
            phase_delay_reg <= PHASE_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RESOLUTION:  resolution_reg  <= cfg_data[RES_W-1:0];
                CFG_PHASE_DELAY: phase_delay_reg <= cfg_data[DELAY_W-1:0];
                default:         ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (evt_ch.ready)
        begin
            s1_valid_reg <= evt_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            s1_kind_reg   <= kind_t'(evt_ch.kind);
            s1_demand_reg <= evt_ch.power_demand;
        end
    end

    // Demand clamp and debt arithmetic for a firing decision.
    assign res_signed     = $signed({1'b0, resolution_reg});
    assign demand_clamped = (s1_demand_reg > res_signed) ? res_signed : s1_demand_reg;
    assign debt_sum       = {1'b0, debt_reg}
                          + (DEBT_W+1)'(resolution_reg)
                          - (DEBT_W+1)'(demand_clamped[RES_W-1:0]);
    assign debt_less      = debt_sum - (DEBT_W+1)'(resolution_reg);

    // Next state for the event in the input register.
    always_comb
    begin
        debt_next      = debt_reg;
        ticks_next     = ticks_reg;
        phase_cnt_next = phase_cnt_reg;
        armed_next     = armed_reg;
        heater_next    = heater_reg;
        energy_next    = energy_reg;
        decided_next   = 1'b0;

        unique case (s1_kind_reg)
            KIND_ZERO_CROSS:
            begin
                if (ticks_reg >= MIN_CROSS_TICKS)
                begin
                    ticks_next     = '0;
                    phase_cnt_next = '0;
                    armed_next     = 1'b1;
                end
            end
            KIND_PHASE_TICK:
            begin
                if (armed_reg)
                begin
                    if (phase_cnt_reg >= phase_delay_reg)
                    begin
                        armed_next     = 1'b0;
                        phase_cnt_next = '0;
                        decided_next   = 1'b1;
                        if (demand_clamped <= 0)
                        begin
                            heater_next = 1'b0;
                            debt_next   = '0;
                        end
                        else if (debt_sum >= (DEBT_W+1)'(resolution_reg))
                        begin
                            heater_next = 1'b0;
                            debt_next   = debt_less[DEBT_W-1:0];
                        end
                        else
                        begin
                            heater_next = 1'b1;
                            energy_next = energy_reg + ENERGY_W'(1);
                            debt_next   = debt_sum[DEBT_W-1:0];
                        end
                    end
                    else
                    begin
                        phase_cnt_next = phase_cnt_reg + DELAY_W'(1);
                    end
                end
            end
            KIND_RT_TICK:
            begin
                // Watchdog: no qualified crossing for too long forces the gate off.
                if (ticks_reg > MIN_CROSS_TICKS)
                begin
                    heater_next = 1'b0;
                end
                if (ticks_reg < TICK_MAX)
                begin
                    ticks_next = ticks_reg + TICK_W'(1);
                end
            end
            KIND_CLEAR_ENERGY:
            begin
                energy_next = '0;
            end
            default:
            begin
                energy_next = energy_reg;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debt_reg      <= '0;
            ticks_reg     <= '0;
            phase_cnt_reg <= '0;
            armed_reg     <= 1'b0;
            heater_reg    <= 1'b0;
            energy_reg    <= '0;
        end
        else if (s1_fire)
        begin
            debt_reg      <= debt_next;
            ticks_reg     <= ticks_next;
            phase_cnt_reg <= phase_cnt_next;
            armed_reg     <= armed_next;
            heater_reg    <= heater_next;
            energy_reg    <= energy_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_heater_reg  <= heater_next;
            out_decided_reg <= decided_next;
            out_energy_reg  <= energy_next;
        end
    end

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.heater_on    = out_heater_reg;
    assign res_ch.decided      = out_decided_reg;
    assign res_ch.energy_count = out_energy_reg;

    // A decision that fires adds exactly one to the energy count.
    a_fire_counts: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && decided_next && heater_next |=> energy_reg == $past(energy_reg) + 32'd1)
        else $error("fired half-cycle not counted");

    // After a decision the phase counter is disarmed.
    a_decision_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && decided_next |=> !armed_reg && phase_cnt_reg == '0)
        else $error("phase counter still armed after decision");

    // A real-time tick never lowers the tick counter.
    a_tick_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_kind_reg == KIND_RT_TICK |=> ticks_reg >= $past(ticks_reg))
        else $error("tick counter decreased on a real-time tick");

    // An empty input stage always takes a new transaction.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> evt_ch.ready)
        else $error("input stage empty but not ready");

endmodule

// File: tb/sv/tbf_firing_scoreboard_pkg.sv
// Scoreboard package: expected-result predictor and result checker for the burst-fire modulator.
`timescale 1ns / 1ps

package tbf_firing_scoreboard_pkg;
    import tbf_pkg::*;

    // One expected result transaction.
    typedef struct packed {
        logic                heater_on;
        logic                decided;
        logic [ENERGY_W-1:0] energy_count;
    } gate_outcome_t;

    class firing_scoreboard;
        // Register copies.
        logic [RES_W-1:0]    resolution;
        logic [DELAY_W-1:0]  phase_delay;

        // Modulator state copies.
        logic [DEBT_W-1:0]   debt;
        logic [TICK_W-1:0]   ticks_since_cross;
        logic [DELAY_W-1:0]  phase_count;
        logic                armed;
        logic                heater;
        logic [ENERGY_W-1:0] energy;

        // Results owed by the block, oldest first.
        gate_outcome_t       outcomes_due[$];

        int unsigned         events_seen;
        int unsigned         results_seen;
        int unsigned         decisions_seen;
        int unsigned         fires_seen;
        int unsigned         failures;

        // State after reset.
        function void power_up();
            resolution        = RESOLUTION_RST;
            phase_delay       = PHASE_DELAY_RST;
            debt              = '0;
            ticks_since_cross = '0;
            phase_count       = '0;
            armed             = 1'b0;
            heater            = 1'b0;
            energy            = '0;
            outcomes_due.delete();
            events_seen       = 0;
            results_seen      = 0;
            decisions_seen    = 0;
            fires_seen        = 0;
            failures          = 0;
        endfunction

        function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_RESOLUTION:  resolution  = value[RES_W-1:0];
                CFG_PHASE_DELAY: phase_delay = value[DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return outcomes_due.size();
        endfunction

        // Density modulation: the debt decides whether this half-cycle fires.
        function void settle_firing(logic signed [DEMAND_W-1:0] demand);
            int want;
            int sum;
            want = int'(demand);
            if (want > int'(resolution))
                want = int'(resolution);
            if (want <= 0)
            begin
                heater = 1'b0;
                debt   = '0;
            end
            else
            begin
                sum = int'(debt) + int'(resolution) - want;
                if (sum >= int'(resolution))
                begin
                    sum    = sum - int'(resolution);
                    heater = 1'b0;
                end
                else
                begin
                    heater = 1'b1;
                    energy = energy + ENERGY_W'(1);
                end
                debt = sum[DEBT_W-1:0];
            end
        endfunction

        // Advance the predicted state by one accepted event and queue its result.
        function void note_event(kind_t kind, logic signed [DEMAND_W-1:0] demand);
            gate_outcome_t due;
            due.decided = 1'b0;
            events_seen++;
            case (kind)
                KIND_ZERO_CROSS:
                begin
                    if (ticks_since_cross >= MIN_CROSS_TICKS)
                    begin
                        ticks_since_cross = '0;
                        phase_count       = '0;
                        armed             = 1'b1;
                    end
                end
                KIND_PHASE_TICK:
                begin
                    if (armed)
                    begin
                        if (phase_count >= phase_delay)
                        begin
                            armed       = 1'b0;
                            phase_count = '0;
                            due.decided = 1'b1;
                            settle_firing(demand);
                        end
                        else
                        begin
                            phase_count = phase_count + DELAY_W'(1);
                        end
                    end
                end
                KIND_RT_TICK:
                begin
                    // Mains loss: no accepted crossing for too long forces the gate off.
                    if (ticks_since_cross > MIN_CROSS_TICKS)
                        heater = 1'b0;
                    if (ticks_since_cross < TICK_MAX)
                        ticks_since_cross = ticks_since_cross + TICK_W'(1);
                end
                default:
                begin
                    energy = '0;
                end
            endcase
            due.heater_on    = heater;
            due.energy_count = energy;
            outcomes_due.push_back(due);
        endfunction

        // Compare one result transaction with the oldest expectation.
        function void check_outcome(logic heater_on, logic decided,
                                    logic [ENERGY_W-1:0] energy_count);
            gate_outcome_t due;
            results_seen++;
            if (outcomes_due.size() == 0)
            begin
                $error("unexpected result: heater_on=%0b decided=%0b energy_count=%0d",
                       heater_on, decided, energy_count);
                failures++;
                return;
            end
            due = outcomes_due.pop_front();
            if (due.decided)
                decisions_seen++;
            if (due.decided && due.heater_on)
                fires_seen++;
            if (heater_on !== due.heater_on)
            begin
                $error("heater_on: expected %0b, actual %0b", due.heater_on, heater_on);
                failures++;
            end
            if (decided !== due.decided)
            begin
                $error("decided: expected %0b, actual %0b", due.decided, decided);
                failures++;
            end
            if (energy_count !== due.energy_count)
            begin
                $error("energy_count: expected %0d, actual %0d", due.energy_count,
                       energy_count);
                failures++;
            end
        endfunction
    endclass

endpackage

// File: tb/sv/tb_triac_burst_fire_modulator_core.sv
// Testbench top for the burst-fire modulator core: stimulus, handshake monitors and watchdog.
`timescale 1ns / 1ps

module tb_triac_burst_fire_modulator_core;
    import tbf_pkg::*;
    import tbf_firing_scoreboard_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tbf_evt_if evt_ch ();
    tbf_res_if res_ch ();

    firing_scoreboard sb;

    int unsigned burst_left;
    int unsigned idle_cycles;
    int unsigned rx_cycle;
    int unsigned rx_mode;
    int unsigned settings_used;

    triac_burst_fire_modulator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt_ch    (evt_ch.sink),
        .res_ch    (res_ch.source)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Monitors: every accepted transaction goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_ch.valid && evt_ch.ready)
                sb.note_event(kind_t'(evt_ch.kind), evt_ch.power_demand);
            if (res_ch.valid && res_ch.ready)
                sb.check_outcome(res_ch.heater_on, res_ch.decided, res_ch.energy_count);
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result-side ready follows one of four randomly chosen patterns, some with stalls.
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 97 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 3) != 0);
            2: res_ch.ready <= ((rx_cycle % 8) < 5);
            default: res_ch.ready <= $urandom_range(0, 1);
        endcase
    end

    // Drive one event transaction; the sender works in bursts with gaps between them.
    task automatic send_event(input kind_t kind, input logic signed [DEMAND_W-1:0] demand);
        if (burst_left == 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                 : $urandom_range(1, 4))
                @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
        evt_ch.valid        <= 1'b1;
        evt_ch.kind         <= kind;
        evt_ch.power_demand <= demand;
        burst_left--;
        do
            @(posedge clk);
        while (!(evt_ch.valid && evt_ch.ready));
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic wait_for_quiet();
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers on two consecutive edges while the block is idle.
    task automatic configure(input logic [RES_W-1:0] res, input logic [DELAY_W-1:0] delay);
        logic [CFG_DATA_W-1:0] delay_word;
        delay_word = {2'($urandom_range(0, 3)), delay};
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RESOLUTION;
        cfg_data  <= CFG_DATA_W'(res);
        @(posedge clk);
        cfg_index <= CFG_PHASE_DELAY;
        cfg_data  <= delay_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_register(CFG_RESOLUTION, CFG_DATA_W'(res));
        sb.write_register(CFG_PHASE_DELAY, delay_word);
        settings_used++;
    endtask

    // Demand values weighted toward off, saturation and the in-range band.
    function automatic logic signed [DEMAND_W-1:0] pick_demand();
        int unsigned res;
        logic [DEMAND_W-1:0] raw;
        res = sb.resolution;
        raw = DEMAND_W'($urandom);
        case ($urandom_range(0, 9))
            0: return DEMAND_W'(-1);
            1: return '0;
            2, 3: return raw;
            4: return DEMAND_W'(res);
            5: return DEMAND_W'($urandom_range(res, 1023));
            default: return (res == 0) ? '0 : DEMAND_W'($urandom_range(1, res));
        endcase
    endfunction

    // Mostly well-formed half-cycles with random content, mixed with noise.
    task automatic run_half_cycles(input int budget);
        int sent;
        int taps;
        int tails;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 78)
            begin
                send_event(KIND_ZERO_CROSS, pick_demand());
                taps = sb.phase_delay + 1;
                if ($urandom_range(0, 9) == 0)
                    taps = $urandom_range(0, taps + 1);
                repeat (taps) send_event(KIND_PHASE_TICK, pick_demand());
                tails = 2;
                case ($urandom_range(0, 9))
                    0: tails = 1;
                    1: tails = $urandom_range(3, 5);
                    default: ;
                endcase
                repeat (tails) send_event(KIND_RT_TICK, pick_demand());
                if ($urandom_range(0, 19) == 0)
                    send_event(KIND_CLEAR_ENERGY, pick_demand());
                sent += 1 + taps + tails;
            end
            else
            begin
                send_event(kind_t'($urandom_range(0, 3)), pick_demand());
                sent++;
            end
        end
        wait_for_quiet();
    endtask

    initial
    begin
        sb = new();
        sb.power_up();
        burst_left    = 0;
        idle_cycles   = 0;
        rx_cycle      = 0;
        rx_mode       = 0;
        settings_used = 1;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_RESOLUTION;
        cfg_data            <= '0;
        evt_ch.valid        <= 1'b0;
        evt_ch.kind         <= KIND_ZERO_CROSS;
        evt_ch.power_demand <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings.
        send_event(KIND_PHASE_TICK, DEMAND_W'(500));    // not armed, ignored
        send_event(KIND_ZERO_CROSS, '0);                // too soon after reset, rejected
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_ZERO_CROSS, '0);
        send_event(KIND_PHASE_TICK, DEMAND_W'(1023));   // saturates to full scale, fires
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_ZERO_CROSS, '0);
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_ZERO_CROSS, '0);                // re-armed while armed, count restarts
        send_event(KIND_PHASE_TICK, DEMAND_W'(-1));     // off, debt cleared
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_ZERO_CROSS, '0);
        send_event(KIND_PHASE_TICK, DEMAND_W'(100));    // exactly full scale
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_RT_TICK, '0);                   // crossings lost, gate forced off
        send_event(KIND_CLEAR_ENERGY, '0);
        send_event(KIND_ZERO_CROSS, '0);
        send_event(KIND_PHASE_TICK, DEMAND_W'(-1024));  // most negative demand
        send_event(KIND_CLEAR_ENERGY, DEMAND_W'(-1));
        wait_for_quiet();

        // Full scale resolution builds a large debt at low demand.
        configure(10'd1023, 8'd0);
        run_half_cycles(30);

        // Smallest nonzero resolution: the old debt drains one step per decision.
        configure(10'd1, 8'd2);
        run_half_cycles(20);

        // Zero resolution keeps the gate off.
        configure(10'd0, 8'd1);
        run_half_cycles(15);

        // Long phase delay; real-time ticks in between saturate the tick counter.
        configure(10'd7, 8'd127);
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_RT_TICK, '0);
        send_event(KIND_ZERO_CROSS, pick_demand());
        for (int i = 0; i < 128; i++)
        begin
            send_event(KIND_PHASE_TICK, pick_demand());
            send_event(KIND_RT_TICK, pick_demand());
            send_event(KIND_RT_TICK, pick_demand());
        end
        send_event(KIND_RT_TICK, '0);
        wait_for_quiet();

        // Random settings with short delays.
        configure(RES_W'($urandom_range(2, 1022)), DELAY_W'($urandom_range(0, 4)));
        run_half_cycles(20);
        configure(RES_W'($urandom_range(2, 1022)), DELAY_W'($urandom_range(0, 3)));
        run_half_cycles(20);

        repeat (8) @(posedge clk);
        $display("Run covered %0d events and %0d results under %0d register settings.",
                 sb.events_seen, sb.results_seen, settings_used);
        $display("It saw %0d firing decisions, %0d of them fired.",
                 sb.decisions_seen, sb.fires_seen);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
src/tbf_pkg.sv
src/tbf_evt_if.sv
src/tbf_res_if.sv
src/triac_burst_fire_modulator_core.sv
tb/sv/tbf_firing_scoreboard_pkg.sv
tb/sv/tb_triac_burst_fire_modulator_core.sv
